// ----- rtl/opaque_region_bbox_scanner_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the opaque region bounding-box scanner
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef OPAQUE_REGION_BBOX_SCANNER_TOP_DEFINES_SVH
`define OPAQUE_REGION_BBOX_SCANNER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define ORBS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define ORBS_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ORBS_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define ORBS_ASSERT_NXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- rtl/orbs_pkg.sv -----
// ----------------------------------------------------------------------------
// orbs_pkg
// Shared types and constants of the opaque region bounding-box scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package orbs_pkg;

  // Fixed field widths.
  localparam int unsigned ALPHA_W = 8;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned ROW_W   = 12;
  localparam int unsigned OUT_W   = 13;
  localparam int unsigned IDX_W   = 2;

  // Reset values of the configuration registers.
  localparam logic [DIM_W-1:0] DIM_RESET       = 13'd4096;
  localparam logic [ROW_W-1:0] START_ROW_RESET = 12'd0;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_START_ROW    = 2'd2
  } cfg_reg_t;

  // One input pixel.
  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic               covered;
  } pixel_t;

  // Configuration seen by the scan core, with a one-cycle restart pulse.
  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic [ROW_W-1:0] start_row;
    logic             restart;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic             found;
    logic [OUT_W-1:0] box_left;
    logic [OUT_W-1:0] box_top;
    logic [OUT_W-1:0] box_width;
    logic [OUT_W-1:0] box_height;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/opaque_region_bbox_scanner_top.sv -----
// ----------------------------------------------------------------------------
// opaque_region_bbox_scanner_top
// Streams pixels in raster order and reports the first opaque region's box.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the in_ stream, one transfer per pixel, row by row from
//   the configured start row: in_tdata carries alpha, in_tuser the covered
//   flag. At most one result per frame leaves on the out_ stream, when the
//   first row that adds nothing to the box ends or when the frame ends.
//   The cfg_ channel writes image_width, image_height and start_row; every
//   write to one of them restarts the frame scan and is always accepted.
//   Result path: the pixel that ends the scan passes the input register,
//   then the result register, whose valid flag drives out_tvalid.
//   Throughput: one pixel per cycle while no result is stalled, set by the
//   combinational box update between the input and result registers.
//   Reset (synchronous, rst_n low) restores width and height 4096, start
//   row 0, and clears the scan state and the valid flags of both stream registers.
//   When the receiver stalls with a result pending, the core holds; the
//   input register takes at most one more pixel, then in_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none
`include "opaque_region_bbox_scanner_top_defines.svh"

module opaque_region_bbox_scanner_top #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] alpha
  input  wire logic [0:0]  in_tuser,   // [0] covered
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // [12:0] box_left, [25:13] box_top,
                                       // [38:26] box_width, [51:39] box_height,
                                       // [55:52] zero
  output logic [0:0]       out_tuser,  // [0] found
  // Configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);

  orbs_pkg::cfg_t    cfg;
  orbs_pkg::pixel_t  in_pix;
  orbs_pkg::pixel_t  pix;
  orbs_pkg::result_t res;
  logic              pix_valid;
  logic              take;

  assign in_pix.alpha   = in_tdata;
  assign in_pix.covered = in_tuser[0];

  orbs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  orbs_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_pix    (in_pix),
    .take      (take),
    .pix_valid (pix_valid),
    .pix       (pix)
  );

  orbs_scan_core #(
    .MAX_DIM (MAX_DIM)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .pix_valid (pix_valid),
    .pix       (pix),
    .take      (take),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // Pack the result fields, box_left in the lowest bits, zero padding on top.
  assign out_tdata = {4'b0000, res.box_height, res.box_width, res.box_top, res.box_left};
  assign out_tuser = res.found;

  // A result without a region carries an all-zero box.
  `ORBS_ASSERT_IMP(a_empty_box_zero, clk, rst_n, out_tvalid && !out_tuser[0],
                   out_tdata == '0, "result without region has nonzero box")
  // The input side only backs up when the input register is full.
  `ORBS_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !pix_valid, in_tready,
                   "in_tready low with empty input register")
  // A stalled result blocks the core, so a full input register stops taking pixels.
  `ORBS_ASSERT_IMP(a_stall_backpressure, clk, rst_n, pix_valid && out_tvalid && !out_tready,
                   !in_tready && !take, "core advanced while result stalled")
  // A pixel taken into an empty input register is held there on the next cycle.
  `ORBS_ASSERT_NXT(a_pixel_held, clk, rst_n, in_tvalid && in_tready && !take, pix_valid,
                   "accepted pixel was lost")

endmodule

`default_nettype wire

// ----- rtl/orbs_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// orbs_cfg_regs
// Configuration register file; a valid write to one of the three registers restarts the frame scan.
// ----------------------------------------------------------------------------
`default_nettype none

module orbs_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [orbs_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [orbs_pkg::DIM_W-1:0] cfg_data,
  output orbs_pkg::cfg_t                  cfg
);

  logic [orbs_pkg::DIM_W-1:0] width_r,   width_nxt;
  logic [orbs_pkg::DIM_W-1:0] height_r,  height_nxt;
  logic [orbs_pkg::ROW_W-1:0] start_r,   start_nxt;
  logic                       restart_r, restart_nxt;
  logic                       wr;

  // The user must issue writes only while the block is idle; the block does not enforce this. Writes are always taken.
  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  // Decode the register index of a write transfer.
  always_comb begin
    width_nxt   = width_r;
    height_nxt  = height_r;
    start_nxt   = start_r;
    restart_nxt = 1'b0;
    if (wr) begin
      case (cfg_index)
        orbs_pkg::CFG_IMAGE_WIDTH: begin
          width_nxt   = cfg_data;
          restart_nxt = 1'b1;
        end
        orbs_pkg::CFG_IMAGE_HEIGHT: begin
          height_nxt  = cfg_data;
          restart_nxt = 1'b1;
        end
        orbs_pkg::CFG_START_ROW: begin
          start_nxt   = cfg_data[orbs_pkg::ROW_W-1:0];
          restart_nxt = 1'b1;
        end
        default: begin
          restart_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= orbs_pkg::DIM_RESET;
      height_r  <= orbs_pkg::DIM_RESET;
      start_r   <= orbs_pkg::START_ROW_RESET;
      restart_r <= 1'b0;
    end else begin
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      start_r   <= start_nxt;
      restart_r <= restart_nxt;
    end
  end

  // The new value takes effect on the cycle after the write, together with
  // the restart pulse to the scan state.
  assign cfg.image_width  = width_r;
  assign cfg.image_height = height_r;
  assign cfg.start_row    = start_r;
  assign cfg.restart      = restart_r;

endmodule

`default_nettype wire

// ----- rtl/orbs_in_stage.sv -----
// ----------------------------------------------------------------------------
// orbs_in_stage
// Input register that decouples the pixel stream from the scan core.
// ----------------------------------------------------------------------------
`default_nettype none

module orbs_in_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire orbs_pkg::pixel_t in_pix,
  input  wire logic             take,
  output logic                  pix_valid,
  output orbs_pkg::pixel_t      pix
);

  logic             valid_r, valid_nxt;
  orbs_pkg::pixel_t pix_r;
  logic             load;

  // Room for a new pixel whenever the register is empty or drains this cycle.
  assign in_tready = !valid_r || take;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      pix_r <= in_pix;
    end
  end

  assign pix_valid = valid_r;
  assign pix       = pix_r;

endmodule

`default_nettype wire

// ----- rtl/orbs_scan_core.sv -----
// ----------------------------------------------------------------------------
// orbs_scan_core
// Per-pixel box growth logic with the scan state and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module orbs_scan_core #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire orbs_pkg::cfg_t   cfg,
  input  wire logic             pix_valid,
  input  wire orbs_pkg::pixel_t pix,
  output logic                  take,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output orbs_pkg::result_t     res
);

  // Coordinates wrap modulo 2**CW, twice the power of two at or above MAX_DIM.
  localparam int unsigned CW   = $clog2(MAX_DIM) + 1;
  localparam int unsigned CMPW = (CW + 1 > orbs_pkg::DIM_W) ? CW + 1 : orbs_pkg::DIM_W;
  localparam int unsigned DW   = (CW > orbs_pkg::OUT_W) ? CW : orbs_pkg::OUT_W;

  logic [CW-1:0] col_r,       col_nxt;
  logic [CW-1:0] row_r,       row_nxt;
  logic          started_r,   started_nxt;
  logic          in_run_r,    in_run_nxt;
  logic          touched_r,   touched_nxt;
  logic          stopped_r,   stopped_nxt;
  logic [CW-1:0] box_left_r,  box_left_nxt;
  logic [CW-1:0] box_right_r, box_right_nxt;
  logic [CW-1:0] box_top_r,   box_top_nxt;
  logic [CW-1:0] box_bot_r,   box_bot_nxt;
  logic [CW-1:0] run_left_r,  run_left_nxt;
  logic [CW-1:0] run_right_r, run_right_nxt;

  logic              res_valid_r, res_valid_nxt;
  orbs_pkg::result_t res_r, res_nxt;

  logic          solid;
  logic          row_end;
  logic          frame_end;
  logic          emit;
  logic [DW-1:0] diff_w;
  logic [DW-1:0] diff_h;

  // The core consumes a pixel whenever the result register can take a result.
  assign take = pix_valid && (!res_valid_r || res_ready);

  assign solid     = (pix.alpha != '0) && !pix.covered;
  assign row_end   = (CMPW'(col_r) + CMPW'(1)) >= CMPW'(cfg.image_width);
  assign frame_end = row_end && ((CMPW'(row_r) + CMPW'(1)) >= CMPW'(cfg.image_height));

  // Scan update for one pixel.
  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    started_nxt   = started_r;
    in_run_nxt    = in_run_r;
    touched_nxt   = touched_r;
    stopped_nxt   = stopped_r;
    box_left_nxt  = box_left_r;
    box_right_nxt = box_right_r;
    box_top_nxt   = box_top_r;
    box_bot_nxt   = box_bot_r;
    run_left_nxt  = run_left_r;
    run_right_nxt = run_right_r;
    emit          = 1'b0;

    if (!stopped_r) begin
      // Open the box on the first solid pixel, or open a new run.
      if (solid) begin
        if (started_r) begin
          if (!in_run_r) begin
            in_run_nxt    = 1'b1;
            run_left_nxt  = col_r;
            run_right_nxt = col_r;
          end
        end else begin
          started_nxt   = 1'b1;
          in_run_nxt    = 1'b1;
          touched_nxt   = 1'b1;
          box_left_nxt  = col_r;
          box_right_nxt = col_r;
          box_top_nxt   = row_r;
          box_bot_nxt   = row_r;
          run_left_nxt  = col_r;
          run_right_nxt = col_r;
        end
      end else if (in_run_r) begin
        in_run_nxt    = 1'b0;
        run_left_nxt  = '0;
        run_right_nxt = '0;
      end

      // A run that overlaps or touches the span widens it.
      if (in_run_nxt) begin
        run_right_nxt = col_r + CW'(1);
        if (!(run_right_nxt < box_left_nxt || run_left_nxt > box_right_nxt)) begin
          touched_nxt = 1'b1;
          if (run_left_nxt < box_left_nxt) begin
            box_left_nxt = run_left_nxt;
          end
          if (run_right_nxt > box_right_nxt) begin
            box_right_nxt = run_right_nxt;
          end
        end
      end

      // End of row: extend the bottom, or stop on a row that adds nothing.
      if (row_end) begin
        if (touched_nxt) begin
          box_bot_nxt = row_r + CW'(1);
        end
        if (started_nxt && !touched_nxt) begin
          stopped_nxt = 1'b1;
          emit        = 1'b1;
        end
        in_run_nxt    = 1'b0;
        touched_nxt   = 1'b0;
        run_left_nxt  = '0;
        run_right_nxt = '0;
      end

      if (frame_end) begin
        emit = 1'b1;
      end
    end

    // Result as seen after this pixel's update.
    diff_w = DW'(box_right_nxt) - DW'(box_left_nxt);
    diff_h = DW'(box_bot_nxt) - DW'(box_top_nxt);
    if (started_nxt) begin
      res_nxt.found      = 1'b1;
      res_nxt.box_left   = orbs_pkg::OUT_W'(box_left_nxt);
      res_nxt.box_top    = orbs_pkg::OUT_W'(box_top_nxt);
      res_nxt.box_width  = diff_w[orbs_pkg::OUT_W-1:0];
      res_nxt.box_height = diff_h[orbs_pkg::OUT_W-1:0];
    end else begin
      res_nxt = '0;
    end

    // Advance the position; the frame end rearms the scan.
    if (frame_end) begin
      col_nxt       = '0;
      row_nxt       = CW'(cfg.start_row);
      started_nxt   = 1'b0;
      in_run_nxt    = 1'b0;
      touched_nxt   = 1'b0;
      stopped_nxt   = 1'b0;
      box_left_nxt  = '0;
      box_right_nxt = '0;
      box_top_nxt   = '0;
      box_bot_nxt   = '0;
      run_left_nxt  = '0;
      run_right_nxt = '0;
    end else if (row_end) begin
      col_nxt = '0;
      row_nxt = row_r + CW'(1);
    end else begin
      col_nxt = col_r + CW'(1);
    end
  end

  // Scan state registers; a configuration write restarts the frame.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg.restart) begin
      col_r       <= '0;
      row_r       <= rst_n ? CW'(cfg.start_row) : '0;
      started_r   <= 1'b0;
      in_run_r    <= 1'b0;
      touched_r   <= 1'b0;
      stopped_r   <= 1'b0;
      box_left_r  <= '0;
      box_right_r <= '0;
      box_top_r   <= '0;
      box_bot_r   <= '0;
      run_left_r  <= '0;
      run_right_r <= '0;
    end else if (take) begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      started_r   <= started_nxt;
      in_run_r    <= in_run_nxt;
      touched_r   <= touched_nxt;
      stopped_r   <= stopped_nxt;
      box_left_r  <= box_left_nxt;
      box_right_r <= box_right_nxt;
      box_top_r   <= box_top_nxt;
      box_bot_r   <= box_bot_nxt;
      run_left_r  <= run_left_nxt;
      run_right_r <= run_right_nxt;
    end
  end

  // Result register valid flag.
  always_comb begin
    res_valid_nxt = res_valid_r;
    if (take) begin
      res_valid_nxt = emit;
    end else if (res_ready) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

`default_nettype wire
